// ===== design/bpu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the BMP pixel array unpacker.
// Used by the front, queue, back and top level; depends on nothing else.
package bpu_pkg;

   localparam int DEF_MAX_WIDTH     = 4096;
   localparam int DEF_MAX_HEIGHT    = 4096;
   localparam int DEF_PALETTE_DEPTH = 256;

   localparam int DIM_W      = 13;
   localparam int FMT_W      = 3;
   localparam int ORG_W      = 12;
   localparam int COORD_W    = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // Pixel format codes.
   localparam logic [FMT_W-1:0] FMT_MONO    = 3'd0;
   localparam logic [FMT_W-1:0] FMT_NIBBLE  = 3'd1;
   localparam logic [FMT_W-1:0] FMT_INDEX8  = 3'd2;
   localparam logic [FMT_W-1:0] FMT_GREY8   = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGB16   = 3'd4;
   localparam logic [FMT_W-1:0] FMT_RGB24   = 3'd5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_SIX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y     = 3'd5;

   // Input command codes.
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_DATA    = 1'b1;

   typedef enum logic [2:0] {
      JOB_PAL_WRITE,
      JOB_MONO,
      JOB_NIBBLE,
      JOB_INDEX,
      JOB_DIRECT
   } job_kind_type;

   // One queued job: a palette write or one data byte and its pixels.
   typedef struct packed {
      job_kind_type       kind;
      logic [7:0]         index;     // palette entry, or the data byte
      logic [23:0]        color;     // {red, green, blue}
      logic [2:0]         last_idx;  // pixel count minus one
      logic [COORD_W-1:0] x_base;
      logic [COORD_W-1:0] y;
      logic               img_end;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ===== design/bmp_pixel_array_unpacker_top.sv =====
`timescale 1ns / 1ps
// BMP pixel array unpacker, top level: front, job queue and back part.
// A byte's pixels pass the job queue, the palette read stage and the output register.
// Throughput: one beat per cycle while the queue is not full, rsp is not stalled and
// each byte yields at most one pixel; a mono byte yields up to eight pixels and a 4-bit
// byte up to two, at the back part's one pixel per cycle palette read port. Synchronous
// active-high reset clears all control state, sets register defaults, spares the palette.
module bmp_pixel_array_unpacker_top
   import bpu_pkg::*;
#(
   parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index, entry_red, entry_green, entry_blue, data_byte
   input  logic [39:0]           req_tdata,
   // cmd
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_x, pixel_y, red, green, blue, zero fill
   output logic [55:0]           rsp_tdata,
   // last_of_item
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic               push, pop;
   job_type            push_job, head;
   queue_stat_type     qstat;
   logic [COORD_W-1:0] px, py;
   logic [7:0]         red, green, blue;

   bpu_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_index   (req_tdata[7:0]),
      .in_red     (req_tdata[15:8]),
      .in_green   (req_tdata[23:16]),
      .in_blue    (req_tdata[31:24]),
      .in_byte    (req_tdata[39:32]),
      .queue_full (qstat.full),
      .push       (push),
      .job        (push_job)
   );

   bpu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .stat     (qstat)
   );

   bpu_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!qstat.empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_x      (px),
      .out_y      (py),
      .out_red    (red),
      .out_green  (green),
      .out_blue   (blue),
      .out_last   (rsp_tuser),
      .out_end    (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, blue, green, red, py, px};

   // The image can only end on the last pixel of a byte.
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("image end flagged on a pixel that is not the last of its byte");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("job popped from an empty queue");

endmodule

// ===== design/bpu_front.sv =====
`timescale 1ns / 1ps
// Front part: configuration registers, row and column tracking, padding skip
// and byte assembly. Turns each accepted beat into at most one job. Uses bpu_pkg.
module bpu_front
   import bpu_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_cmd,
   input  logic [7:0]            in_index,
   input  logic [7:0]            in_red,
   input  logic [7:0]            in_green,
   input  logic [7:0]            in_blue,
   input  logic [7:0]            in_byte,
   input  logic                  queue_full,
   output logic                  push,
   output job_type               job
);

   localparam int COL_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [FMT_W-1:0] fmt_ff;
   logic             g6_ff;
   logic [ORG_W-1:0] ox_ff, oy_ff;

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]       phase_ff, phase_in;
   logic [15:0]      held_ff, held_in;
   logic [1:0]       pad_ff, pad_in;
   logic             finished_ff, finished_in;

   logic [31:0]      w_full, h_full;
   logic [COL_W-1:0] w, rem, col_next;
   logic [ROW_W-1:0] h, row_inc;
   logic             accept, is_data, skip, wrap, restart;
   logic [3:0]       n;
   logic [1:0]       row_bytes, pad_new;
   logic [COL_W:0]   w_plus;
   logic [15:0]      word;
   logic [23:0]      color;
   job_kind_type     kind;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign restart  = csr_we && (csr_index <= REG_ORIGIN_Y);

   always_comb begin
      w_full = (width_ff == '0) ? 32'd1 :
               (32'(width_ff) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_ff);
      h_full = (height_ff == '0) ? 32'd1 :
               (32'(height_ff) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_ff);
      w = w_full[COL_W-1:0];
      h = h_full[ROW_W-1:0];
   end

   assign rem      = w - column_ff;
   assign is_data  = accept && (in_cmd == CMD_DATA) && !finished_ff && (fmt_ff <= FMT_RGB24);
   assign skip     = (pad_ff != 2'd0);
   assign word     = {in_byte, held_ff[7:0]};
   assign col_next = column_ff + COL_W'(n);
   assign wrap     = (col_next >= w);
   assign row_inc  = row_ff + ROW_W'(1);
   assign w_plus   = {1'b0, w} + (COL_W+1)'(7);

   // Pixel count and color of the current byte.
   always_comb begin
      n     = 4'd0;
      kind  = JOB_DIRECT;
      color = {in_byte, in_byte, in_byte};
      unique case (fmt_ff)
         FMT_MONO: begin
            kind = JOB_MONO;
            n    = (rem < COL_W'(8)) ? rem[3:0] : 4'd8;
         end
         FMT_NIBBLE: begin
            kind = JOB_NIBBLE;
            n    = (rem >= COL_W'(2)) ? 4'd2 : 4'd1;
         end
         FMT_INDEX8: begin
            kind = JOB_INDEX;
            n    = 4'd1;
         end
         FMT_GREY8: begin
            n = 4'd1;
         end
         FMT_RGB16: begin
            n = (phase_ff == 2'd0) ? 4'd0 : 4'd1;
            if (g6_ff) begin
               color = {word[15:11], 3'd0, word[10:5], 2'd0, word[4:0], 3'd0};
            end else begin
               color = {word[14:10], 3'd0, word[9:5], 3'd0, word[4:0], 3'd0};
            end
         end
         FMT_RGB24: begin
            n     = (phase_ff == 2'd2) ? 4'd1 : 4'd0;
            color = {in_byte, held_ff[15:8], held_ff[7:0]};
         end
         default: begin
            n = 4'd0;
         end
      endcase
   end

   // Row length in bytes, modulo four, and the padding that follows it.
   always_comb begin
      unique case (fmt_ff)
         FMT_MONO:   row_bytes = w_plus[4:3];
         FMT_NIBBLE: row_bytes = w_plus[2:1] + {1'b0, w[0]} - {1'b0, w[0]} + 2'd0;
         FMT_RGB16:  row_bytes = {w[0], 1'b0};
         FMT_RGB24:  row_bytes = w[1:0] + {w[0], 1'b0};
         default:    row_bytes = w[1:0];
      endcase
      if (fmt_ff == FMT_NIBBLE) begin
         row_bytes = 2'((({1'b0, w} + (COL_W+1)'(1)) >> 1));
      end
      pad_new = 2'd0 - row_bytes;
   end

   always_comb begin
      column_in   = column_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      pad_in      = pad_ff;
      finished_in = finished_ff;
      if (restart) begin
         column_in   = '0;
         row_in      = '0;
         phase_in    = 2'd0;
         held_in     = 16'd0;
         pad_in      = 2'd0;
         finished_in = 1'b0;
      end else if (is_data) begin
         if (skip) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            if (fmt_ff == FMT_RGB16 || fmt_ff == FMT_RGB24) begin
               if (n != 4'd0) begin
                  phase_in = 2'd0;
                  held_in  = 16'd0;
               end else if (phase_ff == 2'd0) begin
                  phase_in = 2'd1;
                  held_in  = {8'd0, in_byte};
               end else begin
                  phase_in = 2'd2;
                  held_in  = {in_byte, held_ff[7:0]};
               end
            end
            if (n != 4'd0) begin
               if (wrap) begin
                  column_in = '0;
                  row_in    = row_inc;
                  pad_in    = pad_new;
                  if (row_inc >= h) begin
                     finished_in = 1'b1;
                  end
               end else begin
                  column_in = col_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_W'(1);
         height_ff   <= DIM_W'(1);
         fmt_ff      <= FMT_MONO;
         g6_ff       <= 1'b0;
         ox_ff       <= '0;
         oy_ff       <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
         phase_ff    <= 2'd0;
         held_ff     <= 16'd0;
         pad_ff      <= 2'd0;
         finished_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         pad_ff      <= pad_in;
         finished_ff <= finished_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               REG_PIXEL_FORMAT: fmt_ff    <= csr_wdata[FMT_W-1:0];
               REG_GREEN_SIX:    g6_ff     <= csr_wdata[0];
               REG_ORIGIN_X:     ox_ff     <= csr_wdata[ORG_W-1:0];
               REG_ORIGIN_Y:     oy_ff     <= csr_wdata[ORG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign push = accept && ((in_cmd == CMD_PALETTE) || (is_data && !skip && (n != 4'd0)));

   always_comb begin
      job          = '0;
      if (in_cmd == CMD_PALETTE) begin
         job.kind  = JOB_PAL_WRITE;
         job.index = in_index;
         job.color = {in_red, in_green, in_blue};
      end else begin
         job.kind     = kind;
         job.index    = in_byte;
         job.color    = color;
         job.last_idx = 3'(n - 4'd1);
         job.x_base   = {{(COORD_W-ORG_W){ox_ff[ORG_W-1]}}, ox_ff} + COORD_W'(column_ff);
         job.y        = {{(COORD_W-ORG_W){oy_ff[ORG_W-1]}}, oy_ff} + COORD_W'(h)
                        - COORD_W'(1) - COORD_W'(row_ff);
         job.img_end  = wrap && (row_inc >= h);
      end
   end

endmodule

// ===== design/bpu_fifo.sv =====
`timescale 1ns / 1ps
// Short job queue between the front and the back part.
// Holds QUEUE_DEPTH jobs of job_type; uses bpu_pkg.
module bpu_fifo
   import bpu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  job_type        push_job,
   input  logic           pop,
   output job_type        head,
   output queue_stat_type stat
);

   job_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]    count_ff;

   assign head       = entries_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QUEUE_AW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QUEUE_AW+1)'(1);
         end
      end
   end

endmodule

// ===== design/bpu_back.sv =====
`timescale 1ns / 1ps
// Back part: palette memory, pixel expansion one pixel per cycle while the output
// is not stalled, palette read stage and output register. Uses bpu_pkg.
module bpu_back
   import bpu_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  job_type            head,
   input  logic               head_valid,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [COORD_W-1:0] out_x,
   output logic [COORD_W-1:0] out_y,
   output logic [7:0]         out_red,
   output logic [7:0]         out_green,
   output logic [7:0]         out_blue,
   output logic               out_last,
   output logic               out_end
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);

   logic [23:0] pal_mem [PALETTE_DEPTH];
   logic [23:0] rd_ff;

   logic [2:0]         idx_ff;
   logic               s1_valid_ff, s1_direct_ff, s1_oob_ff, s1_last_ff, s1_end_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic [23:0]        s1_color_ff;

   logic               out_valid_ff, out_last_ff, out_end_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [23:0]        out_color_ff;

   logic       out_ok, adv, take, is_wr, last_px, oob;
   logic [7:0] pal_idx;

   assign out_ok  = !out_valid_ff || out_ready;
   assign adv     = !s1_valid_ff || out_ok;
   assign take    = adv && head_valid;
   assign is_wr   = (head.kind == JOB_PAL_WRITE);
   assign last_px = (idx_ff == head.last_idx);
   assign pop     = take && (is_wr || last_px);

   // Palette entry for the pixel at the head; mono takes the most significant bit first.
   always_comb begin
      unique case (head.kind)
         JOB_MONO:   pal_idx = {7'd0, head.index[3'd7 - idx_ff]};
         JOB_NIBBLE: pal_idx = (idx_ff == 3'd0) ? {4'd0, head.index[7:4]}
                                                : {4'd0, head.index[3:0]};
         default:    pal_idx = head.index;
      endcase
   end

   assign oob = (32'(pal_idx) >= 32'(PALETTE_DEPTH));

   always_ff @(posedge clock) begin
      if (take && is_wr && !oob) begin
         pal_mem[pal_idx[PAL_AW-1:0]] <= head.color;
      end
      if (adv) begin
         rd_ff <= pal_mem[pal_idx[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take && !is_wr) begin
            idx_ff <= last_px ? 3'd0 : idx_ff + 3'd1;
         end
         if (adv) begin
            s1_valid_ff <= take && !is_wr;
         end
         if (out_ok) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff      <= head.x_base + COORD_W'(idx_ff);
         s1_y_ff      <= head.y;
         s1_direct_ff <= (head.kind == JOB_DIRECT);
         s1_oob_ff    <= oob;
         s1_color_ff  <= head.color;
         s1_last_ff   <= last_px;
         s1_end_ff    <= head.img_end && last_px;
      end
      if (out_ok && s1_valid_ff) begin
         out_x_ff     <= s1_x_ff;
         out_y_ff     <= s1_y_ff;
         out_last_ff  <= s1_last_ff;
         out_end_ff   <= s1_end_ff;
         out_color_ff <= s1_direct_ff ? s1_color_ff : (s1_oob_ff ? 24'd0 : rd_ff);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_red   = out_color_ff[23:16];
   assign out_green = out_color_ff[15:8];
   assign out_blue  = out_color_ff[7:0];
   assign out_last  = out_last_ff;
   assign out_end   = out_end_ff;

endmodule
